### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Each macro checks a property on the rising clock edge, outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define WGP_ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define WGP_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define WGP_ASSERT_PROP(label, clk, rst_n, prop)

`define WGP_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

### hw/rtl/wgp_pkg.sv
package wgp_pkg;

    localparam int POS_W      = 32;
    localparam int QUAT_W     = 16;
    localparam int NUM_QUAT   = 4;
    localparam int SD_W       = 24;
    localparam int AXES       = 3;
    localparam int AXIS_W     = 2;
    localparam int MAG_W      = POS_W;
    localparam int SQ_W       = 2 * MAG_W + 2;
    localparam int DIST_W     = MAG_W + 1;
    localparam int PROD_W     = MAG_W + DIST_W;
    localparam int REM_W      = DIST_W + 3;
    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int DIV_STEPS  = MAG_W;
    localparam int CNT_W      = 6;
    localparam int DATA_W     = AXES * POS_W + NUM_QUAT * QUAT_W;
    localparam int USER_W     = 1;

    localparam logic [SD_W-1:0] SD_RESET = 24'd19661;

    typedef logic signed [POS_W-1:0] pos_t;

    typedef enum logic [1:0] {
        EMIT_FIRST,
        EMIT_PASS,
        EMIT_PULL
    } emit_kind_t;

    typedef struct packed {
        logic              load;
        logic              sq_step;
        logic              root_step;
        logic              keep_calc;
        logic              prod_step;
        logic              div_step;
        logic              emit;
        emit_kind_t        emit_kind;
        logic [AXIS_W-1:0] axis;
    } wgp_cmd_t;

    typedef struct packed {
        logic have_ref;
        logic dist_ge;
        logic out_free;
    } wgp_status_t;

endpackage

### hw/rtl/wgp_ctrl.sv
`include "assert_macros.svh"

module wgp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 path_start,
    input  wgp_pkg::wgp_status_t status,
    output wgp_pkg::wgp_cmd_t    cmd
);
    import wgp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_KEEP,
        ST_PROD,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    emit_kind_t       kind_reg;
    logic             accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        cmd           = '0;
        cmd.emit_kind = kind_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = accept;
            end
            ST_SQUARE:
            begin
                cmd.sq_step = 1'b1;
                cmd.axis    = cnt_reg[AXIS_W-1:0];
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
            end
            ST_KEEP:
            begin
                cmd.keep_calc = 1'b1;
            end
            ST_PROD:
            begin
                cmd.prod_step = 1'b1;
                cmd.axis      = cnt_reg[AXIS_W-1:0];
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                cmd.load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            kind_reg  <= EMIT_FIRST;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cnt_reg <= '0;
                        if (path_start || !status.have_ref)
                        begin
                            kind_reg  <= EMIT_FIRST;
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            state_reg <= ST_SQUARE;
                        end
                    end
                end
                ST_SQUARE:
                begin
                    if (cnt_reg == CNT_W'(AXES - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_ROOT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_ROOT:
                begin
                    if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_KEEP;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_KEEP:
                begin
                    if (status.dist_ge)
                    begin
                        state_reg <= ST_PROD;
                    end
                    else
                    begin
                        kind_reg  <= EMIT_PASS;
                        state_reg <= ST_FINISH;
                    end
                end
                ST_PROD:
                begin
                    if (cnt_reg == CNT_W'(AXES - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_DIVIDE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_DIVIDE:
                begin
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    begin
                        cnt_reg   <= '0;
                        kind_reg  <= EMIT_PULL;
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_FINISH:
                begin
                    if (status.out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `WGP_ASSERT_PROP(a_accept_leaves_idle, clk, rst_n,
        accept |=> (state_reg == ST_SQUARE || state_reg == ST_FINISH))
    `WGP_ASSERT_NEVER(a_div_count_bound, clk, rst_n,
        state_reg == ST_DIVIDE && cnt_reg >= CNT_W'(DIV_STEPS))

endmodule

### hw/rtl/wgp_dp.sv
`include "assert_macros.svh"

module wgp_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [wgp_pkg::SD_W-1:0]      cfg_wdata,
    input  logic [wgp_pkg::DATA_W-1:0]    in_data,
    input  wgp_pkg::wgp_cmd_t             cmd,
    output wgp_pkg::wgp_status_t          status,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [wgp_pkg::DATA_W-1:0]    m_axis_tdata,
    output logic [wgp_pkg::USER_W-1:0]    m_axis_tuser
);
    import wgp_pkg::*;

    logic [SD_W-1:0]             sd_reg;
    logic                        have_ref_reg;
    logic                        m_valid_reg;
    logic [DATA_W-1:0]           m_data_reg;
    logic [USER_W-1:0]           m_user_reg;

    pos_t                        in_pos_reg [AXES];
    pos_t                        ref_reg    [AXES];
    logic [NUM_QUAT*QUAT_W-1:0]  quat_reg;
    logic [MAG_W-1:0]            mag_reg    [AXES];
    logic                        neg_reg    [AXES];
    logic [SQ_W-1:0]             acc_reg;
    logic [REM_W-1:0]            rem_reg;
    logic [DIST_W-1:0]           root_reg;
    logic [DIST_W-1:0]           keep_reg;
    logic [PROD_W-1:0]           rq_reg     [AXES];

    pos_t                        in_pos     [AXES];
    logic [MAG_W-1:0]            in_mag     [AXES];
    logic                        in_neg     [AXES];
    logic [MAG_W-1:0]            mul_a;
    logic [DIST_W-1:0]           mul_b;
    logic [PROD_W-1:0]           mul_p;
    logic [REM_W-1:0]            sq_trial;
    logic [REM_W-1:0]            sq_t;
    logic                        sq_ge;
    logic [REM_W-1:0]            rem_next;
    logic [DIST_W-1:0]           root_next;
    logic [PROD_W-1:0]           rq_next    [AXES];
    pos_t                        pull_pos   [AXES];
    pos_t                        out_pos    [AXES];
    logic                        out_free;

    // Operand capture: the difference to the reference is kept as sign and magnitude.
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            logic [POS_W:0] fwd;
            logic [POS_W:0] back;
            in_pos[i] = in_data[i*POS_W +: POS_W];
            fwd       = {in_pos[i][POS_W-1], in_pos[i]} - {ref_reg[i][POS_W-1], ref_reg[i]};
            back      = {ref_reg[i][POS_W-1], ref_reg[i]} - {in_pos[i][POS_W-1], in_pos[i]};
            in_neg[i] = fwd[POS_W];
            in_mag[i] = fwd[POS_W] ? back[MAG_W-1:0] : fwd[MAG_W-1:0];
        end
    end

    // One shared multiplier serves the squares and the scaled differences.
    assign mul_a = mag_reg[cmd.axis];
    assign mul_b = cmd.prod_step ? keep_reg : {1'b0, mul_a};
    assign mul_p = mul_a * mul_b;

    // Square root, one result bit per step.
    assign sq_t      = {rem_reg[REM_W-3:0], acc_reg[SQ_W-1 -: 2]};
    assign sq_trial  = REM_W'({root_reg, 2'b01});
    assign sq_ge     = sq_t >= sq_trial;
    assign rem_next  = sq_ge ? sq_t - sq_trial : sq_t;
    assign root_next = {root_reg[DIST_W-2:0], sq_ge};

    // Three restoring divider lanes; the quotient shifts in below the remainder.
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            logic [DIST_W:0]   t;
            logic [DIST_W:0]   r;
            logic              ge;
            t  = rq_reg[i][PROD_W-1:MAG_W-1];
            ge = t >= {1'b0, root_reg};
            r  = ge ? t - {1'b0, root_reg} : t;
            rq_next[i] = {r[DIST_W-1:0], rq_reg[i][MAG_W-2:0], ge};
        end
    end

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            if (root_reg == '0)
            begin
                pull_pos[i] = ref_reg[i];
            end
            else if (neg_reg[i])
            begin
                pull_pos[i] = ref_reg[i] - pos_t'(rq_reg[i][MAG_W-1:0]);
            end
            else
            begin
                pull_pos[i] = ref_reg[i] + pos_t'(rq_reg[i][MAG_W-1:0]);
            end
            out_pos[i] = (cmd.emit_kind == EMIT_PULL) ? pull_pos[i] : in_pos_reg[i];
        end
    end

    assign out_free        = !m_valid_reg || m_axis_tready;
    assign status.have_ref = have_ref_reg;
    assign status.dist_ge  = root_reg >= DIST_W'(sd_reg);
    assign status.out_free = out_free;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sd_reg       <= SD_RESET;
            have_ref_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                sd_reg <= cfg_wdata;
            end
            if (cmd.emit && cmd.emit_kind == EMIT_FIRST)
            begin
                have_ref_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            quat_reg <= in_data[DATA_W-1:AXES*POS_W];
            acc_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            for (int i = 0; i < AXES; i++)
            begin
                in_pos_reg[i] <= in_pos[i];
                mag_reg[i]    <= in_mag[i];
                neg_reg[i]    <= in_neg[i];
            end
        end
        if (cmd.sq_step)
        begin
            acc_reg <= acc_reg + SQ_W'(mul_p);
        end
        if (cmd.root_step)
        begin
            acc_reg  <= acc_reg << 2;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
        if (cmd.keep_calc)
        begin
            keep_reg <= root_reg - DIST_W'(sd_reg);
        end
        if (cmd.prod_step)
        begin
            rq_reg[cmd.axis] <= mul_p;
        end
        if (cmd.div_step)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                rq_reg[i] <= rq_next[i];
            end
        end
        if (cmd.emit)
        begin
            m_data_reg <= {quat_reg, out_pos[2], out_pos[1], out_pos[0]};
            m_user_reg <= USER_W'(cmd.emit_kind == EMIT_PULL);
            if (cmd.emit_kind != EMIT_PASS)
            begin
                for (int i = 0; i < AXES; i++)
                begin
                    ref_reg[i] <= out_pos[i];
                end
            end
        end
    end

    `WGP_ASSERT_PROP(a_emit_shows, clk, rst_n,
        cmd.emit |=> m_axis_tvalid)
    `WGP_ASSERT_PROP(a_ref_follows_out, clk, rst_n,
        (cmd.emit && cmd.emit_kind != EMIT_PASS) |=>
            (have_ref_reg && ref_reg[0] == $signed(m_axis_tdata[POS_W-1:0])))
    `WGP_ASSERT_PROP(a_pass_not_pulled, clk, rst_n,
        (cmd.emit && cmd.emit_kind == EMIT_PASS) |=> !m_axis_tuser[0])

endmodule

### hw/rtl/waypoint_goal_pullback.sv
// Channel     Direction  Handshake                   Payload
// s_axis      in         s_axis_tvalid/tready        tdata waypoint, tuser path start
// m_axis      out        m_axis_tvalid/tready        tdata corrected point, tuser pulled flag
// cfg         in         cfg_we                      cfg_wdata safety distance
//
// One request is worked on at a time. A first waypoint of a path goes straight to the output.
// Any other waypoint runs through the squares and the 33-step square root up to the
// distance compare and, when pulled back, through the products and the 32-step divider.
// The finished result waits in the output register while the next request is accepted.
// Reset clears the reference flag and sets the safety distance to 0.3 m.
module waypoint_goal_pullback (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [wgp_pkg::SD_W-1:0]      cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w
    input  logic [wgp_pkg::DATA_W-1:0]    s_axis_tdata,
    // path_start
    input  logic [wgp_pkg::USER_W-1:0]    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_x, out_y, out_z, out_qx, out_qy, out_qz, out_qw
    output logic [wgp_pkg::DATA_W-1:0]    m_axis_tdata,
    // was_pulled_back
    output logic [wgp_pkg::USER_W-1:0]    m_axis_tuser
);
    import wgp_pkg::*;

    wgp_cmd_t    cmd;
    wgp_status_t status;

    wgp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_axis_tvalid),
        .s_tready   (s_axis_tready),
        .path_start (s_axis_tuser[0]),
        .status     (status),
        .cmd        (cmd)
    );

    wgp_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_data       (s_axis_tdata),
        .cmd           (cmd),
        .status        (status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

### tb/waypoint_goal_pullback_test.sv
module waypoint_goal_pullback_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wgp_pkg::*;

    typedef struct {
        logic                     path_start;
        pos_t                     pos_x;
        pos_t                     pos_y;
        pos_t                     pos_z;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
        logic signed [QUAT_W-1:0] quat_w;
    } waypoint_t;

    typedef struct {
        pos_t                     out_x;
        pos_t                     out_y;
        pos_t                     out_z;
        logic signed [QUAT_W-1:0] out_qx;
        logic signed [QUAT_W-1:0] out_qy;
        logic signed [QUAT_W-1:0] out_qz;
        logic signed [QUAT_W-1:0] out_qw;
        logic                     pulled;
    } goal_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [SD_W-1:0]     cfg_wdata = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [DATA_W-1:0]   s_axis_tdata = '0;
    logic [USER_W-1:0]   s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [DATA_W-1:0]   m_axis_tdata;
    logic [USER_W-1:0]   m_axis_tuser;

    waypoint_t waypoint_backlog[$];
    goal_t     planned_goals[$];

    longint          ref_pos_x = 0;
    longint          ref_pos_y = 0;
    longint          ref_pos_z = 0;
    bit              have_ref = 1'b0;
    logic [SD_W-1:0] stop_dist = SD_RESET;

    int  error_count = 0;
    int  request_count = 0;
    bit  request_taken = 1'b0;
    bit  idle_on = 1'b1;
    int  send_gap = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    longint anchor_x = 0;
    longint anchor_y = 0;
    longint anchor_z = 0;

    waypoint_goal_pullback uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #10ms;
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    task automatic compare_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want)
        begin
            report_mismatch(what, got, want);
        end
    endtask

    function automatic longint shorten_axis(longint origin, longint delta,
                                            logic [127:0] radius, logic [127:0] keep);
        logic [127:0] span;
        logic [127:0] step;
        if (radius == 0)
        begin
            return origin;
        end
        span = (delta < 0) ? 128'(-delta) : 128'(delta);
        step = (span * keep) / radius;
        return (delta < 0) ? origin - longint'(step[63:0]) : origin + longint'(step[63:0]);
    endfunction

    // Works out the goal for one accepted request and advances the reference point unless it passes.
    function automatic goal_t plan_goal(waypoint_t w);
        goal_t        g;
        longint       dx;
        longint       dy;
        longint       dz;
        logic [127:0] mx;
        logic [127:0] my;
        logic [127:0] mz;
        logic [127:0] dist_sq;
        logic [127:0] root;
        logic [127:0] trial;
        logic [127:0] keep;
        longint       nx;
        longint       ny;
        longint       nz;
        g.out_x = w.pos_x;
        g.out_y = w.pos_y;
        g.out_z = w.pos_z;
        g.out_qx = w.quat_x;
        g.out_qy = w.quat_y;
        g.out_qz = w.quat_z;
        g.out_qw = w.quat_w;
        g.pulled = 1'b0;
        if (w.path_start || !have_ref)
        begin
            ref_pos_x = longint'(w.pos_x);
            ref_pos_y = longint'(w.pos_y);
            ref_pos_z = longint'(w.pos_z);
            have_ref = 1'b1;
        end
        else
        begin
            dx = longint'(w.pos_x) - ref_pos_x;
            dy = longint'(w.pos_y) - ref_pos_y;
            dz = longint'(w.pos_z) - ref_pos_z;
            mx = (dx < 0) ? 128'(-dx) : 128'(dx);
            my = (dy < 0) ? 128'(-dy) : 128'(dy);
            mz = (dz < 0) ? 128'(-dz) : 128'(dz);
            dist_sq = mx * mx + my * my + mz * mz;
            root = '0;
            for (int b = 35; b >= 0; b--)
            begin
                trial = root | (128'd1 << b);
                if (trial * trial <= dist_sq)
                begin
                    root = trial;
                end
            end
            if (root >= 128'(stop_dist))
            begin
                keep = root - 128'(stop_dist);
                nx = shorten_axis(ref_pos_x, dx, root, keep);
                ny = shorten_axis(ref_pos_y, dy, root, keep);
                nz = shorten_axis(ref_pos_z, dz, root, keep);
                ref_pos_x = nx;
                ref_pos_y = ny;
                ref_pos_z = nz;
                g.out_x = nx[31:0];
                g.out_y = ny[31:0];
                g.out_z = nz[31:0];
                g.pulled = 1'b1;
            end
        end
        return g;
    endfunction

    task automatic queue_waypoint(logic start, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                  logic [15:0] qx, logic [15:0] qy, logic [15:0] qz,
                                  logic [15:0] qw);
        waypoint_t w;
        w.path_start = start;
        w.pos_x = x;
        w.pos_y = y;
        w.pos_z = z;
        w.quat_x = qx;
        w.quat_y = qy;
        w.quat_z = qz;
        w.quat_w = qw;
        waypoint_backlog.insert(waypoint_backlog.size(), w);
        anchor_x = longint'(w.pos_x);
        anchor_y = longint'(w.pos_y);
        anchor_z = longint'(w.pos_z);
    endtask

    function automatic logic [31:0] near_anchor(longint anchor, int unsigned span);
        longint offset;
        if ($urandom_range(0, 3) == 0)
        begin
            return anchor[31:0];
        end
        offset = longint'($urandom_range(0, 2 * span)) - longint'(span);
        return 32'(anchor + offset);
    endfunction

    task automatic queue_random_waypoints(int count);
        int unsigned span;
        logic        start;
        for (int n = 0; n < count; n++)
        begin
            start = ($urandom_range(0, 9) == 0);
            case ($urandom_range(0, 11))
                0, 1:
                    queue_waypoint(start, $urandom, $urandom, $urandom,
                                   16'($urandom), 16'($urandom), 16'($urandom),
                                   16'($urandom));
                2:
                    queue_waypoint(start, anchor_x[31:0], anchor_y[31:0], anchor_z[31:0],
                                   16'($urandom), 16'($urandom), 16'($urandom),
                                   16'($urandom));
                3:
                    queue_waypoint(start, 32'(anchor_x + longint'(stop_dist)),
                                   anchor_y[31:0], anchor_z[31:0],
                                   16'($urandom), 16'($urandom), 16'($urandom),
                                   16'($urandom));
                default:
                begin
                    case ($urandom_range(0, 3))
                        0: span = int'(stop_dist) / 2 + 1;
                        1: span = 2 * int'(stop_dist) + 2;
                        2: span = 1 << 20;
                        default: span = 1 << 30;
                    endcase
                    queue_waypoint(start, near_anchor(anchor_x, span),
                                   near_anchor(anchor_y, span), near_anchor(anchor_z, span),
                                   16'($urandom), 16'($urandom), 16'($urandom),
                                   16'($urandom));
                end
            endcase
        end
    endtask

    task automatic wait_until_drained();
        do
        begin
            @(posedge clk);
        end
        while (waypoint_backlog.size() != 0 || s_axis_tvalid || planned_goals.size() != 0);
    endtask

    task automatic set_stop_distance(logic [SD_W-1:0] value);
        wait_until_drained();
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        stop_dist = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    always @(negedge clk)
    begin
        waypoint_t w;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!s_axis_tvalid || request_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (waypoint_backlog.size() > 0)
            begin
                w = waypoint_backlog.pop_front();
                s_axis_tdata <= {w.quat_w, w.quat_z, w.quat_y, w.quat_x,
                                 w.pos_z, w.pos_y, w.pos_x};
                s_axis_tuser <= w.path_start;
                s_axis_tvalid <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0)
                begin
                    send_gap = $urandom_range(1, 17);
                end
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // The receiver stalls at random and holds off once for a long stretch so that the block fills up.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!hold_done && request_count >= 700)
        begin
            hold_done = 1'b1;
            hold_left = 400;
            m_axis_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 17);
            end
        end
    end

    always @(posedge clk)
    begin
        waypoint_t w;
        goal_t     want;
        request_taken <= s_axis_tvalid && s_axis_tready;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                w.pos_x = s_axis_tdata[31:0];
                w.pos_y = s_axis_tdata[63:32];
                w.pos_z = s_axis_tdata[95:64];
                w.quat_x = s_axis_tdata[111:96];
                w.quat_y = s_axis_tdata[127:112];
                w.quat_z = s_axis_tdata[143:128];
                w.quat_w = s_axis_tdata[159:144];
                w.path_start = s_axis_tuser[0];
                planned_goals.insert(planned_goals.size(), plan_goal(w));
                request_count++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (planned_goals.size() == 0)
                begin
                    report_mismatch("unrequested result", m_axis_tdata[31:0], '0);
                end
                else
                begin
                    want = planned_goals.pop_front();
                    compare_field("out_x", m_axis_tdata[31:0], want.out_x);
                    compare_field("out_y", m_axis_tdata[63:32], want.out_y);
                    compare_field("out_z", m_axis_tdata[95:64], want.out_z);
                    compare_field("out_qx", 32'(m_axis_tdata[111:96]),
                                  32'($unsigned(want.out_qx)));
                    compare_field("out_qy", 32'(m_axis_tdata[127:112]),
                                  32'($unsigned(want.out_qy)));
                    compare_field("out_qz", 32'(m_axis_tdata[143:128]),
                                  32'($unsigned(want.out_qz)));
                    compare_field("out_qw", 32'(m_axis_tdata[159:144]),
                                  32'($unsigned(want.out_qw)));
                    compare_field("was_pulled_back", 32'(m_axis_tuser[0]), 32'(want.pulled));
                end
            end
        end
    end

    initial
    begin
        logic [SD_W-1:0] phase_dist[6];
        phase_dist[0] = 24'd1;
        phase_dist[1] = 24'($urandom);
        phase_dist[2] = 24'hFFFFFF;
        phase_dist[3] = 24'd0;
        phase_dist[4] = 24'($urandom_range(0, 4000000));
        phase_dist[5] = SD_RESET;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // With the reset safety distance: no reference yet, near, exact, far and extremes.
        queue_waypoint(1'b0, 32'h7FFFFFFF, 32'h80000000, 32'h0,
                       16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF);
        queue_waypoint(1'b0, 32'h7FFFFFFF, 32'h80000000, 32'd10000,
                       16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000);
        queue_waypoint(1'b0, 32'h7FFFFFFF, 32'h80000000 + 32'd19661, 32'h0,
                       16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
        queue_waypoint(1'b0, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                       16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_waypoint(1'b1, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h7FFF);
        queue_waypoint(1'b0, -32'sd327680, 32'sd196608, -32'sd1,
                       16'h0, 16'h0, 16'h0, 16'h7FFF);
        queue_waypoint(1'b1, 32'h80000000, 32'h80000000, 32'h80000000,
                       16'h8000, 16'h8000, 16'h8000, 16'h8000);
        queue_waypoint(1'b0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                       16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        queue_waypoint(1'b0, 32'h12345678, 32'hDEADBEEF, 32'h0F0F0F0F,
                       16'h0, 16'h0, 16'h0, 16'h0);

        // Zero safety distance: a repeated point is still pulled back onto itself.
        set_stop_distance(24'd0);
        queue_waypoint(1'b1, 32'd100, 32'd200, 32'd300, 16'h0, 16'h0, 16'h0, 16'h4000);
        queue_waypoint(1'b0, 32'd100, 32'd200, 32'd300, 16'h0, 16'h0, 16'h0, 16'h4000);
        queue_waypoint(1'b0, 32'd101, 32'd200, 32'd300, 16'h0, 16'h0, 16'h0, 16'h4000);
        queue_waypoint(1'b0, -32'sd5, 32'sd7, 32'sd300000, 16'h0, 16'h0, 16'h0, 16'h4000);

        set_stop_distance(24'hFFFFFF);
        queue_waypoint(1'b1, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h4000);
        queue_waypoint(1'b0, 32'd16777215, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h4000);
        queue_waypoint(1'b0, 32'd16777214, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h4000);
        queue_waypoint(1'b0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                       16'h0, 16'h0, 16'h0, 16'h4000);
        queue_waypoint(1'b0, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                       16'h0, 16'h0, 16'h0, 16'h4000);

        for (int p = 0; p < 6; p++)
        begin
            set_stop_distance(phase_dist[p]);
            if (p == 5)
            begin
                idle_on = 1'b0;
            end
            queue_random_waypoints(325);
        end

        wait_until_drained();
        repeat (100) @(posedge clk);
        if (planned_goals.size() != 0)
        begin
            report_mismatch("results still outstanding", 32'(planned_goals.size()), '0);
        end
        if (error_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
